>>> rtl/smm_pkg.sv
// Package: shared constants, types and helpers of the square-window morphology core.
package smm_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;
   localparam int MAX_RADIUS = 4;

   localparam int DIM_W   = $clog2(MAX_WIDTH + 1) > $clog2(MAX_HEIGHT + 1) ?
                            $clog2(MAX_WIDTH + 1) : $clog2(MAX_HEIGHT + 1);
   localparam int COL_W   = $clog2(MAX_WIDTH);
   localparam int ROW_W   = $clog2(MAX_HEIGHT + MAX_RADIUS + 1);
   localparam int RAD_W   = $clog2(MAX_RADIUS + 1);
   localparam int LAG_MAX = MAX_RADIUS * MAX_WIDTH + MAX_RADIUS;
   localparam int CNT_W   = $clog2(MAX_WIDTH * MAX_HEIGHT + LAG_MAX + 1);
   localparam int WIN     = 2 * MAX_RADIUS + 1;
   localparam int HIST_W  = 2 * MAX_RADIUS;
   localparam int PIX_AW  = $clog2(LAG_MAX + 1);
   localparam int PIX_DEPTH = 1 << PIX_AW;
   localparam int CSR_DATA_W = 11;
   localparam int CHAN_W  = 8;

   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
   localparam int RES_W      = $clog2(FIFO_DEPTH + 1);

   localparam int RESET_WIDTH  = 640;
   localparam int RESET_HEIGHT = 480;
   localparam int RESET_RADIUS = 2;
   localparam int RESET_TOTAL  = RESET_WIDTH * RESET_HEIGHT;
   localparam int RESET_LAG    = RESET_RADIUS * RESET_WIDTH + RESET_RADIUS;

   localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

   typedef enum logic [1:0] {
      REG_FRAME_WIDTH,
      REG_FRAME_HEIGHT,
      REG_RADIUS,
      REG_MODE
   } csr_index_type;

   typedef enum logic {
      KIND_PIXEL,
      KIND_FLUSH
   } kind_type;

   typedef enum logic {
      MODE_DILATE,
      MODE_ERODE
   } mode_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } pixel_type;

   localparam pixel_type WHITE_PX = '{red: CHAN_MAX, green: CHAN_MAX, blue: CHAN_MAX};
   localparam pixel_type BLACK_PX = '0;

   typedef struct packed {
      logic [DIM_W-1:0] width;
      logic [DIM_W-1:0] height;
      logic [RAD_W-1:0] radius;
      mode_type         mode;
      logic [CNT_W-1:0] total;
      logic [CNT_W-1:0] lag;
      logic [CNT_W-1:0] span;
   } cfg_type;

   typedef struct packed {
      logic      valid;
      pixel_type pix;
   } step_type;

   typedef struct packed {
      logic busy;
      logic room;
   } win_status_type;

   typedef struct packed {
      logic      valid;
      pixel_type pix;
      logic      frame_end;
   } result_type;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [CSR_DATA_W-1:0] v,
                                                  input int hi);
      logic [DIM_W-1:0] r;
      if (v == '0) r = DIM_W'(1);
      else if (32'(v) > hi) r = DIM_W'(hi);
      else r = DIM_W'(v);
      return r;
   endfunction

   function automatic logic [RAD_W-1:0] clamp_radius(input logic [2:0] v);
      logic [RAD_W-1:0] r;
      if (32'(v) > MAX_RADIUS) r = RAD_W'(MAX_RADIUS);
      else r = RAD_W'(v);
      return r;
   endfunction

endpackage

>>> rtl/smm_if.sv
// Interfaces: request and response channels of the morphology core.
interface smm_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] blue;
   logic [7:0] green;
   logic [7:0] red;

   modport source (output valid, output kind, output blue, output green, output red,
                   input ready);
   modport sink (input valid, input kind, input blue, input green, input red,
                 output ready);
endinterface

interface smm_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_blue;
   logic [7:0] out_green;
   logic [7:0] out_red;
   logic       frame_end;

   modport source (output valid, output out_blue, output out_green, output out_red,
                   output frame_end, input ready);
   modport sink (input valid, input out_blue, input out_green, input out_red,
                 input frame_end, output ready);
endinterface

>>> rtl/square_window_morphology_core.sv
// Top level: configuration registers and wiring of the square-window morphology core.
// Throughput: one transaction per clock in both directions while neither side is held
//   back; the pixel store and the column history RAM each take one read and one write
//   per cycle. Pipeline: stage 0 RAM read, stage 1 vertical window, stage 2 row window
//   into the queue.
// Results are due radius rows plus radius pixels after their pixel; the tail is
//   drained by flush transactions after the frame's last pixel.
// Reset: counters, credits and queue clear; registers go to 640x480, radius 2,
//   dilate. The stores are not cleared; rows above the frame top are masked.
module square_window_morphology_core import smm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  csr_index_type         csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   smm_req_if.sink               req_if,
   smm_rsp_if.source             rsp_if
);

   cfg_type          cfg_ff, cfg_in;
   logic [DIM_W-1:0] width_sel, height_sel;
   logic [RAD_W-1:0] radius_sel;
   mode_type         mode_sel;
   logic [CNT_W-1:0] total_sel, lag_sel;

   step_type         step;
   win_status_type   win_status;
   result_type       result;
   logic             credit_add, pop, req_ready;
   pixel_type        req_pix;

   // pick the written register, clamp it, and rebuild the derived frame sizes
   always_comb begin
      width_sel  = cfg_ff.width;
      height_sel = cfg_ff.height;
      radius_sel = cfg_ff.radius;
      mode_sel   = cfg_ff.mode;
      if (csr_we) begin
         unique case (csr_index)
            REG_FRAME_WIDTH:  width_sel  = clamp_dim(csr_wdata, MAX_WIDTH);
            REG_FRAME_HEIGHT: height_sel = clamp_dim(csr_wdata, MAX_HEIGHT);
            REG_RADIUS:       radius_sel = clamp_radius(csr_wdata[2:0]);
            REG_MODE:         mode_sel   = mode_type'(csr_wdata[0]);
            default:          ;
         endcase
      end
      total_sel = CNT_W'(width_sel) * CNT_W'(height_sel);
      lag_sel   = CNT_W'(radius_sel) * CNT_W'(width_sel) + CNT_W'(radius_sel);
      cfg_in.width  = width_sel;
      cfg_in.height = height_sel;
      cfg_in.radius = radius_sel;
      cfg_in.mode   = mode_sel;
      cfg_in.total  = total_sel;
      cfg_in.lag    = lag_sel;
      cfg_in.span   = total_sel + lag_sel;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.width  <= DIM_W'(RESET_WIDTH);
         cfg_ff.height <= DIM_W'(RESET_HEIGHT);
         cfg_ff.radius <= RAD_W'(RESET_RADIUS);
         cfg_ff.mode   <= MODE_DILATE;
         cfg_ff.total  <= CNT_W'(RESET_TOTAL);
         cfg_ff.lag    <= CNT_W'(RESET_LAG);
         cfg_ff.span   <= CNT_W'(RESET_TOTAL + RESET_LAG);
      end else if (csr_we) begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_pix.blue  = req_if.blue;
   assign req_pix.green = req_if.green;
   assign req_pix.red   = req_if.red;
   assign req_if.ready  = req_ready;

   // hold pixels of a new frame until the engine has drained the previous one
   smm_flow u_flow (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_valid  (req_if.valid),
      .req_kind   (req_if.kind),
      .req_pix    (req_pix),
      .req_ready  (req_ready),
      .win        (win_status),
      .step       (step),
      .credit_add (credit_add)
   );

   // advance one window position per pixel, and on its own through the frame tail
   smm_window u_window (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .step   (step),
      .pop    (pop),
      .status (win_status),
      .result (result)
   );

   // release each result only against a transaction that earned it
   smm_rsp_queue u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (result),
      .credit_add (credit_add),
      .pop        (pop),
      .rsp_if     (rsp_if)
   );

endmodule

>>> rtl/smm_ram.sv
// Generic simple dual-port RAM with registered read.
module smm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/smm_flow.sv
// Admission control: frame counters, result credits and pixel steps.
module smm_flow import smm_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  cfg_type        cfg,
   input  logic           req_valid,
   input  logic           req_kind,
   input  pixel_type      req_pix,
   output logic           req_ready,
   input  win_status_type win,
   output step_type       step,
   output logic           credit_add
);

   logic [CNT_W-1:0] in_cnt_ff, in_cnt_in;
   logic [CNT_W-1:0] out_cnt_ff, out_cnt_in;
   logic [CNT_W-1:0] in_inc, out_inc;
   logic             accept, all_in, is_pixel, out_evt;

   assign all_in    = (in_cnt_ff == cfg.total);
   assign req_ready = !(in_cnt_ff == '0 && win.busy) && (all_in || win.room);
   assign accept    = req_valid && req_ready;
   assign is_pixel  = !all_in && (kind_type'(req_kind) == KIND_PIXEL);
   assign in_inc    = in_cnt_ff + CNT_W'(1);
   assign out_inc   = out_cnt_ff + CNT_W'(1);
   assign out_evt   = all_in ||
                      (is_pixel && (in_inc == cfg.total || in_cnt_ff >= out_cnt_ff + cfg.lag));

   assign credit_add = accept && out_evt;
   assign step.valid = accept && is_pixel;
   assign step.pix   = req_pix;

   always_comb begin
      in_cnt_in  = in_cnt_ff;
      out_cnt_in = out_cnt_ff;
      if (accept) begin
         if (is_pixel) begin
            in_cnt_in = in_inc;
         end
         if (out_evt) begin
            if (out_inc == cfg.total) begin
               in_cnt_in  = '0;
               out_cnt_in = '0;
            end else begin
               out_cnt_in = out_inc;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_cnt_ff  <= '0;
         out_cnt_ff <= '0;
      end else begin
         in_cnt_ff  <= in_cnt_in;
         out_cnt_ff <= out_cnt_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      in_cnt_ff <= cfg.total && out_cnt_ff < cfg.total)
      else $error("frame counters ran past the frame size");

endmodule

>>> rtl/smm_window.sv
// Window engine: line history and pixel stores, vertical and horizontal window reduction.
module smm_window import smm_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  cfg_type        cfg,
   input  step_type       step,
   input  logic           pop,
   output win_status_type status,
   output result_type     result
);

   // position counters of stage 0
   logic [CNT_W-1:0] pos_ff, pos_in, pos_inc, center_pos;
   logic [COL_W-1:0] col_ff, col_in, oc_ff, oc_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [RES_W-1:0] reserved_ff, reserved_in;
   logic             room, tail_step, go, produce, last, col_end, oc_end, flag;

   // stage 1
   logic             s1_valid_ff, s1_produce_ff, s1_last_ff, s1_flag_ff;
   logic [ROW_W-1:0] s1_row_ff;
   logic [COL_W-1:0] s1_col_ff, s1_oc_ff;
   pixel_type        s1_pix_ff, center, pix_rdata;
   logic [HIST_W-1:0] col_rdata, hist, new_hist, last_hist_ff;
   logic [WIN-1:0]   col_bits, hreg_ff;
   logic             vert;

   // stage 2
   logic             s2_valid_ff, s2_last_ff, horiz;
   logic [COL_W-1:0] s2_oc_ff;
   pixel_type        s2_center_ff;
   logic [COL_W+1:0] reach;

   assign room      = reserved_ff < RES_W'(FIFO_DEPTH);
   assign tail_step = (pos_ff >= cfg.total) && room;
   assign go        = step.valid || tail_step;
   assign produce   = pos_ff >= cfg.lag;
   assign pos_inc   = pos_ff + CNT_W'(1);
   assign last      = (pos_inc == cfg.span);
   assign col_end   = ({1'b0, col_ff} == cfg.width - DIM_W'(1));
   assign oc_end    = ({1'b0, oc_ff} == cfg.width - DIM_W'(1));
   assign center_pos = pos_ff - cfg.lag;
   assign flag      = step.valid &&
                      ((cfg.mode == MODE_ERODE) ? (step.pix == WHITE_PX)
                                                : (step.pix == BLACK_PX));

   assign status.busy = (pos_ff != '0);
   assign status.room = room;

   always_comb begin
      pos_in = pos_ff;
      col_in = col_ff;
      row_in = row_ff;
      oc_in  = oc_ff;
      if (go) begin
         if (last) begin
            pos_in = '0;
            col_in = '0;
            row_in = '0;
            oc_in  = '0;
         end else begin
            pos_in = pos_inc;
            if (col_end) begin
               col_in = '0;
               row_in = row_ff + ROW_W'(1);
            end else begin
               col_in = col_ff + COL_W'(1);
            end
            if (produce) begin
               oc_in = oc_end ? '0 : oc_ff + COL_W'(1);
            end
         end
      end
   end

   assign reserved_in = reserved_ff + RES_W'(go && produce) - RES_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         col_ff      <= '0;
         row_ff      <= '0;
         oc_ff       <= '0;
         reserved_ff <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         pos_ff      <= pos_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         oc_ff       <= oc_in;
         reserved_ff <= reserved_in;
         s1_valid_ff <= go;
         s2_valid_ff <= s1_valid_ff && s1_produce_ff;
      end
   end

   smm_ram #(.WIDTH(HIST_W), .DEPTH(MAX_WIDTH)) u_col_ram (
      .clock (clock),
      .we    (s1_valid_ff),
      .waddr (s1_col_ff),
      .wdata (new_hist),
      .raddr (col_ff),
      .rdata (col_rdata)
   );

   smm_ram #(.WIDTH($bits(pixel_type)), .DEPTH(PIX_DEPTH)) u_pix_ram (
      .clock (clock),
      .we    (step.valid),
      .waddr (pos_ff[PIX_AW-1:0]),
      .wdata (step.pix),
      .raddr (center_pos[PIX_AW-1:0]),
      .rdata (pix_rdata)
   );

   always_ff @(posedge clock) begin
      if (go) begin
         s1_row_ff     <= row_ff;
         s1_col_ff     <= col_ff;
         s1_oc_ff      <= oc_ff;
         s1_flag_ff    <= flag;
         s1_pix_ff     <= step.pix;
         s1_produce_ff <= produce;
         s1_last_ff    <= last;
      end
   end

   // one-pixel rows revisit the same column every step: take the last write
   assign hist     = (cfg.width == DIM_W'(1)) ? last_hist_ff : col_rdata;
   assign new_hist = {hist[HIST_W-2:0], s1_flag_ff};
   assign col_bits = {hist, s1_flag_ff};
   assign center   = (cfg.lag == '0) ? s1_pix_ff : pix_rdata;

   always_comb begin
      vert = 1'b0;
      for (int j = 0; j < WIN; j++) begin
         if ((RAD_W+1)'(j) <= {cfg.radius, 1'b0} && ROW_W'(j) <= s1_row_ff) begin
            vert = vert | col_bits[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         last_hist_ff <= new_hist;
         hreg_ff      <= {hreg_ff[WIN-2:0], vert};
         s2_center_ff <= center;
         s2_oc_ff     <= s1_oc_ff;
         s2_last_ff   <= s1_last_ff;
      end
   end

   // entry j of the row window is column oc + radius - j
   assign reach = (COL_W+2)'(s2_oc_ff) + (COL_W+2)'(cfg.radius);

   always_comb begin
      horiz = 1'b0;
      for (int j = 0; j < WIN; j++) begin
         if ((RAD_W+1)'(j) <= {cfg.radius, 1'b0} && reach >= (COL_W+2)'(j) &&
             reach - (COL_W+2)'(j) < (COL_W+2)'(cfg.width)) begin
            horiz = horiz | hreg_ff[j];
         end
      end
   end

   always_comb begin
      result.valid     = s2_valid_ff;
      result.frame_end = s2_last_ff;
      if (cfg.mode == MODE_ERODE) begin
         result.pix = horiz ? WHITE_PX : BLACK_PX;
      end else begin
         result.pix = horiz ? BLACK_PX : s2_center_ff;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      reserved_ff <= RES_W'(FIFO_DEPTH))
      else $error("result slots overbooked");

   assert property (@(posedge clock) disable iff (reset)
      go && last |=> pos_ff == '0 && !status.busy)
      else $error("engine did not wrap after the last position");

endmodule

>>> rtl/smm_rsp_queue.sv
// Result queue: holds computed results and releases one per earned credit.
module smm_rsp_queue import smm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  result_type push,
   input  logic       credit_add,
   output logic       pop,
   smm_rsp_if.source  rsp_if
);

   pixel_type        pix_q [FIFO_DEPTH];
   logic             end_q [FIFO_DEPTH];
   logic [FIFO_AW-1:0] wr_ff, rd_ff;
   logic [RES_W-1:0] count_ff;
   logic [CNT_W-1:0] credit_ff;

   assign rsp_if.valid     = (count_ff != '0) && (credit_ff != '0);
   assign rsp_if.out_blue  = pix_q[rd_ff].blue;
   assign rsp_if.out_green = pix_q[rd_ff].green;
   assign rsp_if.out_red   = pix_q[rd_ff].red;
   assign rsp_if.frame_end = end_q[rd_ff];
   assign pop              = rsp_if.valid && rsp_if.ready;

   always_ff @(posedge clock) begin
      if (push.valid) begin
         pix_q[wr_ff] <= push.pix;
         end_q[wr_ff] <= push.frame_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff     <= '0;
         rd_ff     <= '0;
         count_ff  <= '0;
         credit_ff <= '0;
      end else begin
         if (push.valid) begin
            wr_ff <= wr_ff + FIFO_AW'(1);
         end
         if (pop) begin
            rd_ff <= rd_ff + FIFO_AW'(1);
         end
         count_ff  <= count_ff + RES_W'(push.valid) - RES_W'(pop);
         credit_ff <= credit_ff + CNT_W'(credit_add) - CNT_W'(pop);
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      push.valid |-> count_ff < RES_W'(FIFO_DEPTH) || pop)
      else $error("result pushed into a full queue");

endmodule

>>> tb/tb.sv
// Testbench for the square-window morphology core: random frames checked against a predictor.
module tb;
   import smm_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STORE_DEPTH = (2 * MAX_RADIUS + 1) * MAX_WIDTH;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int ITEM_TARGET = 1150;

   typedef struct {
      pixel_type pix;
      bit        frame_end;
   } morph_result;

   // Predictor of the core plus the queue of pending result pixels.
   class morph_scoreboard;
      pixel_type   store [STORE_DEPTH];
      int unsigned in_cnt, out_cnt;
      bit [10:0]   reg_width = 640, reg_height = 480;
      bit [2:0]    reg_radius = 2;
      mode_type    reg_mode = MODE_DILATE;
      bit          frame_done;
      int          fails;
      morph_result due_q[$];

      function int unsigned eff_width();
         return reg_width == 0 ? 1 : (reg_width > MAX_WIDTH ? MAX_WIDTH : reg_width);
      endfunction
      function int unsigned eff_height();
         return reg_height == 0 ? 1 : (reg_height > MAX_HEIGHT ? MAX_HEIGHT : reg_height);
      endfunction
      function int unsigned eff_radius();
         return reg_radius > MAX_RADIUS ? MAX_RADIUS : reg_radius;
      endfunction
      function int unsigned frame_total();
         return eff_width() * eff_height();
      endfunction

      function void write_reg(csr_index_type idx, bit [10:0] val);
         case (idx)
            REG_FRAME_WIDTH:  reg_width = val;
            REG_FRAME_HEIGHT: reg_height = val;
            REG_RADIUS:       reg_radius = val[2:0];
            default:          reg_mode = mode_type'(val[0]);
         endcase
      endfunction

      // True while the current frame still takes pixels.
      function bit wants_pixels();
         return in_cnt < frame_total();
      endfunction

      function bit window_holds(int row, int col, pixel_type target);
         int w, h, r, r0, r1, c0, c1;
         w = eff_width(); h = eff_height(); r = eff_radius();
         r0 = row >= r ? row - r : 0;
         r1 = row + r < h ? row + r : h - 1;
         c0 = col >= r ? col - r : 0;
         c1 = col + r < w ? col + r : w - 1;
         for (int a = r0; a <= r1; a++)
            for (int b = c0; b <= c1; b++)
               if (store[(a * w + b) % STORE_DEPTH] == target) return 1;
         return 0;
      endfunction

      function void note_input(kind_type kind, pixel_type pix);
         int unsigned w, total, lag;
         pixel_type   center, res;
         morph_result m;
         w = eff_width();
         total = frame_total();
         lag = eff_radius() * w + eff_radius();
         if (in_cnt > total || out_cnt >= total) begin
            in_cnt = 0;
            out_cnt = 0;
         end
         if (in_cnt < total) begin
            // drop flushes while the frame still expects pixels
            if (kind == KIND_FLUSH) return;
            store[in_cnt % STORE_DEPTH] = pix;
            in_cnt++;
            if (in_cnt < total && in_cnt < out_cnt + lag + 1) return;
         end
         center = store[out_cnt % STORE_DEPTH];
         if (reg_mode == MODE_DILATE) begin
            if (center == BLACK_PX || window_holds(out_cnt / w, out_cnt % w, BLACK_PX))
               res = BLACK_PX;
            else
               res = center;
         end else begin
            res = window_holds(out_cnt / w, out_cnt % w, WHITE_PX) ? WHITE_PX : BLACK_PX;
         end
         out_cnt++;
         m.pix = res;
         m.frame_end = out_cnt >= total;
         if (m.frame_end) begin
            in_cnt = 0;
            out_cnt = 0;
            frame_done = 1;
         end
         due_q = {due_q, m};
      endfunction

      task report(string what);
         $display("MISMATCH at %0t: %s", $realtime, what);
         fails++;
      endtask

      task check_result(pixel_type pix, bit frame_end);
         morph_result m;
         if (due_q.size() == 0) begin
            report($sformatf("unexpected result %h", pix));
            return;
         end
         m = due_q.pop_front();
         if (pix.blue != m.pix.blue)
            report($sformatf("out_blue %h, want %h", pix.blue, m.pix.blue));
         if (pix.green != m.pix.green)
            report($sformatf("out_green %h, want %h", pix.green, m.pix.green));
         if (pix.red != m.pix.red)
            report($sformatf("out_red %h, want %h", pix.red, m.pix.red));
         if (frame_end != m.frame_end)
            report($sformatf("frame_end %b, want %b", frame_end, m.frame_end));
      endtask
   endclass

   logic                  clock = 0;
   logic                  reset = 1;
   logic                  csr_we = 0;
   csr_index_type         csr_index = REG_FRAME_WIDTH;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   smm_req_if req ();
   smm_rsp_if rsp ();

   square_window_morphology_core dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_if    (req),
      .rsp_if    (rsp)
   );

   morph_scoreboard sb = new();
   int  idle_pct = 0;     // sender idle chance per cycle
   int  stall_pct = 0;    // receiver stall chance per cycle
   int  hold_req = 0;     // long receiver hold-off requested by the stimulus
   int  items_sent = 0;
   int  cycles = 0;

   always #2 clock = ~clock;

   initial begin
      req.valid = 0;
      req.kind  = KIND_PIXEL;
      req.blue  = 0;
      req.green = 0;
      req.red   = 0;
      rsp.ready = 0;
   end

   // Receiver: random stalls, plus a counted long hold-off when asked.
   int hold_left = 0;
   always @(posedge clock) begin
      if (hold_req != 0) begin
         hold_left <= hold_req;
         hold_req  <= 0;
         rsp.ready <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp.ready <= 0;
      end else begin
         rsp.ready <= $urandom_range(99) >= stall_pct;
      end
   end

   // Check every accepted result transaction.
   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready)
         sb.check_result('{red: rsp.out_red, green: rsp.out_green, blue: rsp.out_blue},
                         rsp.frame_end);
   end

   // Watchdog: end the run if it hangs.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   function automatic pixel_type rand_pixel();
      pixel_type p;
      p = pixel_type'(24'($urandom));
      case ($urandom_range(5))
         0: p = BLACK_PX;
         1, 2: p = WHITE_PX;
         3: p.green = CHAN_MAX;     // near-white but not white
         default: ;
      endcase
      return p;
   endfunction

   // Offer one transaction, hold until accepted, then note it and maybe idle.
   task automatic send(kind_type kind, pixel_type pix);
      req.valid <= 1;
      req.kind  <= kind;
      req.blue  <= pix.blue;
      req.green <= pix.green;
      req.red   <= pix.red;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      sb.note_input(kind, pix);
      items_sent++;
      if ($urandom_range(99) < idle_pct) begin
         req.valid <= 0;
         @(posedge clock);
         while ($urandom_range(99) < idle_pct) @(posedge clock);
      end
   endtask

   // Wait for every pending result, then let the pipeline settle.
   task automatic drain_all();
      req.valid <= 0;
      @(posedge clock);
      while (sb.due_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_cfg(bit [10:0] w, bit [10:0] h, bit [10:0] r, bit [10:0] m);
      csr_index_type idx [4] = '{REG_FRAME_WIDTH, REG_FRAME_HEIGHT, REG_RADIUS, REG_MODE};
      bit [10:0]     val [4];
      val = '{w, h, r, m};
      foreach (idx[i]) begin
         csr_we    <= 1;
         csr_index <= idx[i];
         csr_wdata <= val[i];
         @(posedge clock);
         sb.write_reg(idx[i], val[i]);
      end
      csr_we <= 0;
   endtask

   // One whole frame: pixels with stray flushes, then drain items of any kind.
   task automatic run_frame(bit noise);
      sb.frame_done = 0;
      while (!sb.frame_done && sb.wants_pixels()) begin
         if (noise && $urandom_range(9) == 0) send(KIND_FLUSH, rand_pixel());
         else send(KIND_PIXEL, rand_pixel());
      end
      // past the last pixel every kind counts as flush
      while (!sb.frame_done) send(kind_type'($urandom_range(1)), rand_pixel());
   endtask

   pixel_type directed_px [12];

   initial begin
      int frame_no;
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: 4x3 dilate with radius 1, extremes and a stray flush mid-frame.
      directed_px = '{BLACK_PX, WHITE_PX, 24'hFF0000, 24'h00FF00, 24'h0000FF, 24'h010101,
                      WHITE_PX, WHITE_PX, 24'hFFFFFE, 24'h7F807F, WHITE_PX, 24'hAA55AA};
      write_cfg(11'd4, 11'd3, 11'd1, 11'(MODE_DILATE));
      sb.frame_done = 0;
      foreach (directed_px[i]) begin
         if (i == 5) send(KIND_FLUSH, WHITE_PX);
         send(KIND_PIXEL, directed_px[i]);
      end
      while (!sb.frame_done) send(KIND_PIXEL, 24'h123456);
      drain_all();
      // Same frame eroded.
      write_cfg(11'd4, 11'd3, 11'd1, 11'(MODE_ERODE));
      sb.frame_done = 0;
      foreach (directed_px[i]) send(KIND_PIXEL, directed_px[i]);
      while (!sb.frame_done) send(KIND_FLUSH, BLACK_PX);
      drain_all();

      // Random frames, cycling through the idling phases.
      frame_no = 0;
      while (items_sent < ITEM_TARGET) begin
         bit [10:0] w, h;
         case (frame_no % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 72; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 72; end
            default: begin idle_pct = 20; stall_pct = 20; end
         endcase
         w = 11'($urandom_range(9) == 0 ? 0 : $urandom_range(1, 12));
         h = 11'($urandom_range(9) == 0 ? 0 : $urandom_range(1, 8));
         // a full-size frame under the hold-off so the core backs up
         if (frame_no == 5) begin
            w = 11'd12;
            h = 11'd8;
         end
         write_cfg(w, h, 11'($urandom_range(7)), 11'($urandom_range(1)));
         // hold the receiver off long enough for the core to back up
         if (frame_no == 5) begin
            idle_pct = 0;
            hold_req = 300;
         end
         run_frame(1);
         drain_all();
         frame_no++;
      end

      // Smallest frame with no window at all.
      idle_pct = 10;
      stall_pct = 10;
      write_cfg(11'd1, 11'd1, 11'd0, 11'(MODE_DILATE));
      run_frame(1);
      drain_all();

      repeat (20) @(posedge clock);
      if (sb.fails == 0 && sb.due_q.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end
endmodule
